// ----- rtl/adjacency_matrix_graph_store_unit_macros.svh -----
// Assertion helpers for the graph store. Clock i_clk, reset i_rst_n (active low).
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_UNIT_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_UNIT_MACROS_SVH

// Same-cycle implication.
`define AMG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AMG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/amg_pkg.sv -----
`default_nettype none

package amg_pkg;

    localparam int unsigned MAX_NODES_DEF   = 32;
    localparam int unsigned WEIGHT_BITS_DEF = 16;
    localparam int unsigned MAX_RESULTS     = 32;

    // fixed field widths
    localparam int unsigned OP_W   = 2;
    localparam int unsigned STS_W  = 2;
    localparam int unsigned LBL_W  = 5;
    localparam int unsigned WIN_W  = 16;
    localparam int unsigned RV_W   = 16;
    localparam int unsigned EC_W   = 9;
    localparam int unsigned NCFG_W = 6;
    // compare width: covers node_count and any node count up to 64
    localparam int unsigned CMP_W  = 7;
    localparam int unsigned K_W    = $clog2(MAX_RESULTS + 1);

    localparam logic [NCFG_W-1:0] NODE_COUNT_RST = NCFG_W'(32);
    localparam logic [EC_W-1:0]   EDGE_CNT_MAX   = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_QUERY  = 2'd1,
        OP_LIST   = 2'd2,
        OP_DEGREE = 2'd3
    } t_op;

    typedef enum logic [STS_W-1:0] {
        STS_OK       = 2'd0,
        STS_BAD_EDGE = 2'd1,
        STS_ILLEGAL  = 2'd2,
        STS_NO_NBR   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_CHK,
        S_ADD_WR2,
        S_QUERY,
        S_WALK,
        S_PUSH
    } t_state;

    typedef struct packed {
        t_status           status;
        logic [LBL_W-1:0]  neighbor_node;
        logic [RV_W-1:0]   result_value;
        logic [EC_W-1:0]   edge_count;
        logic              last;
    } t_rsp;

    typedef struct packed {
        logic              clearing;
        logic              idle;
        logic [EC_W-1:0]   edges;
    } t_stat;

    localparam t_rsp RSP_DONE = '{
        status:        STS_OK,
        neighbor_node: '0,
        result_value:  '0,
        edge_count:    '0,
        last:          1'b1
    };

endpackage

`default_nettype wire

// ----- rtl/amg_if.sv -----
`default_nettype none

interface amg_req_if import amg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [LBL_W-1:0] node_u;
    logic [LBL_W-1:0] node_v;
    logic [WIN_W-1:0] edge_weight;

    modport source (output valid, op, node_u, node_v, edge_weight, input ready);
    modport sink   (input valid, op, node_u, node_v, edge_weight, output ready);
endinterface

interface amg_rsp_if import amg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [STS_W-1:0] status;
    logic [LBL_W-1:0] neighbor_node;
    logic [RV_W-1:0]  result_value;
    logic [EC_W-1:0]  edge_count;
    logic             last;

    modport source (output valid, status, neighbor_node, result_value, edge_count, last,
                    input ready);
    modport sink   (input valid, status, neighbor_node, result_value, edge_count, last,
                    output ready);
endinterface

interface amg_cfg_if import amg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NCFG_W-1:0] node_count;

    modport source (output valid, node_count, input ready);
    modport sink   (input valid, node_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/amg_wmem.sv -----
`default_nettype none

module amg_wmem import amg_pkg::*; #(
    parameter int unsigned DEPTH = MAX_NODES_DEF * MAX_NODES_DEF,
    parameter int unsigned WIDTH = WEIGHT_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/amg_out_reg.sv -----
`default_nettype none

module amg_out_reg import amg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_rsp i_rsp,
    output logic      o_ready,
    amg_rsp_if.source o_rsp
);

    logic r_valid;
    logic n_valid;
    t_rsp r_rsp;

    assign o_ready = !r_valid || o_rsp.ready;
    assign n_valid = i_push || (r_valid && !o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.status        = r_rsp.status;
    assign o_rsp.neighbor_node = r_rsp.neighbor_node;
    assign o_rsp.result_value  = r_rsp.result_value;
    assign o_rsp.edge_count    = r_rsp.edge_count;
    assign o_rsp.last          = r_rsp.last;

endmodule

`default_nettype wire

// ----- rtl/amg_ctrl.sv -----
`default_nettype none

module amg_ctrl import amg_pkg::*; #(
    parameter int unsigned MAX_NODES   = MAX_NODES_DEF,
    parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]       i_active_n,
    amg_req_if.sink                                   i_req,
    output logic                                      o_mem_we,
    output logic [$clog2(MAX_NODES*MAX_NODES)-1:0]    o_mem_waddr,
    output logic [WEIGHT_BITS-1:0]                    o_mem_wdata,
    output logic                                      o_mem_re,
    output logic [$clog2(MAX_NODES*MAX_NODES)-1:0]    o_mem_raddr,
    input  wire logic [WEIGHT_BITS-1:0]               i_mem_rdata,
    output logic                                      o_push,
    output t_rsp                                      o_push_rsp,
    input  wire logic                                 i_out_ready,
    output t_stat                                     o_stat
);

    localparam int unsigned DEPTH  = MAX_NODES * MAX_NODES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_NODES);
    localparam logic [K_W-1:0]    K_FINAL    = K_W'(MAX_RESULTS - 1);
    localparam logic [K_W-1:0]    K_PRE      = K_W'(MAX_RESULTS - 2);

    function automatic logic [ADDR_W-1:0] f_addr(input logic [LBL_W-1:0] row,
                                                 input logic [CMP_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ROW_STRIDE) + ADDR_W'(col);
    endfunction

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [LBL_W-1:0]        r_u, n_u;
    logic [LBL_W-1:0]        r_v, n_v;
    logic [WEIGHT_BITS-1:0]  r_w, n_w;
    logic [ADDR_W-1:0]       r_clr, n_clr;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic                    r_rd_v, n_rd_v;
    logic [CNT_W-1:0]        r_deg, n_deg;
    logic                    r_hold_v, n_hold_v;
    logic [LBL_W-1:0]        r_hold_node, n_hold_node;
    logic [WEIGHT_BITS-1:0]  r_hold_w, n_hold_w;
    logic [K_W-1:0]          r_k, n_k;
    logic [EC_W-1:0]         r_edges, n_edges;
    t_rsp                    r_res, n_res;

    logic                    u_ok;
    logic                    v_ok;
    logic [WEIGHT_BITS-1:0]  w_in;
    logic [LBL_W-1:0]        rd_node;
    t_rsp                    hold_rsp;

    assign u_ok    = CMP_W'(i_req.node_u) < CMP_W'(i_active_n);
    assign v_ok    = CMP_W'(i_req.node_v) < CMP_W'(i_active_n);
    assign w_in    = WEIGHT_BITS'(i_req.edge_weight);
    // label of the entry whose data sits on the read port
    assign rd_node = LBL_W'(r_idx - 1'b1);

    assign hold_rsp = '{
        status:        STS_OK,
        neighbor_node: r_hold_node,
        result_value:  RV_W'(r_hold_w),
        edge_count:    r_edges,
        last:          1'b0
    };

    always_comb begin
        logic stall;
        logic fin;

        stall       = 1'b0;
        fin         = 1'b0;
        n_state     = r_state;
        n_op        = r_op;
        n_u         = r_u;
        n_v         = r_v;
        n_w         = r_w;
        n_clr       = r_clr;
        n_idx       = r_idx;
        n_rd_v      = r_rd_v;
        n_deg       = r_deg;
        n_hold_v    = r_hold_v;
        n_hold_node = r_hold_node;
        n_hold_w    = r_hold_w;
        n_k         = r_k;
        n_edges     = r_edges;
        n_res       = r_res;

        i_req.ready = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = f_addr(r_u, CMP_W'(r_v));
        o_mem_wdata = r_w;
        o_mem_re    = 1'b0;
        o_mem_raddr = f_addr(r_u, CMP_W'(r_idx));
        o_push      = 1'b0;
        o_push_rsp  = r_res;
        o_push_rsp.edge_count = r_edges;

        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                o_mem_wdata = '0;
                n_clr       = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_op     = t_op'(i_req.op);
                    n_u      = i_req.node_u;
                    n_v      = i_req.node_v;
                    n_w      = w_in;
                    n_res    = RSP_DONE;
                    n_idx    = '0;
                    n_deg    = '0;
                    n_k      = '0;
                    n_rd_v   = 1'b0;
                    n_hold_v = 1'b0;
                    o_mem_raddr = f_addr(i_req.node_u, CMP_W'(i_req.node_v));
                    unique case (t_op'(i_req.op))
                        OP_ADD: begin
                            if (!u_ok || !v_ok || i_req.node_u == i_req.node_v
                                || w_in == '0) begin
                                n_res.status = STS_BAD_EDGE;
                                n_state      = S_PUSH;
                            end else begin
                                o_mem_re = 1'b1;
                                n_state  = S_ADD_CHK;
                            end
                        end
                        OP_QUERY: begin
                            if (!u_ok || !v_ok) begin
                                n_res.status = STS_ILLEGAL;
                                n_state      = S_PUSH;
                            end else begin
                                o_mem_re = 1'b1;
                                n_state  = S_QUERY;
                            end
                        end
                        OP_LIST, OP_DEGREE: begin
                            if (!u_ok) begin
                                n_res.status = STS_ILLEGAL;
                                n_state      = S_PUSH;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end

            S_ADD_CHK: begin
                if (i_mem_rdata != '0) begin
                    n_res.status = STS_BAD_EDGE;
                    n_state      = S_PUSH;
                end else begin
                    o_mem_we = 1'b1;
                    n_state  = S_ADD_WR2;
                end
            end

            S_ADD_WR2: begin
                // mirror entry
                o_mem_we    = 1'b1;
                o_mem_waddr = f_addr(r_v, CMP_W'(r_u));
                if (r_edges != EDGE_CNT_MAX) begin
                    n_edges = r_edges + 1'b1;
                end
                n_state = S_PUSH;
            end

            S_QUERY: begin
                n_res.result_value = RV_W'(i_mem_rdata);
                n_state            = S_PUSH;
            end

            S_WALK: begin
                // evaluate the entry whose data sits on the read port
                if (r_rd_v && i_mem_rdata != '0) begin
                    if (r_op == OP_DEGREE) begin
                        n_deg = r_deg + 1'b1;
                    end else if (!r_hold_v) begin
                        n_hold_v    = 1'b1;
                        n_hold_node = rd_node;
                        n_hold_w    = i_mem_rdata;
                        fin         = (r_k == K_FINAL);
                    end else if (i_out_ready) begin
                        o_push      = 1'b1;
                        o_push_rsp  = hold_rsp;
                        n_k         = r_k + 1'b1;
                        n_hold_node = rd_node;
                        n_hold_w    = i_mem_rdata;
                        fin         = (r_k == K_PRE);
                    end else begin
                        stall = 1'b1;
                    end
                end

                if (fin) begin
                    // result limit reached: this neighbor closes the listing
                    n_res.neighbor_node = rd_node;
                    n_res.result_value  = RV_W'(i_mem_rdata);
                    n_state             = S_PUSH;
                end else if (!stall) begin
                    if (r_idx != i_active_n) begin
                        o_mem_re = 1'b1;
                        n_idx    = r_idx + 1'b1;
                        n_rd_v   = 1'b1;
                    end else begin
                        n_rd_v = 1'b0;
                        if (!r_rd_v) begin
                            n_state = S_PUSH;
                            if (r_op == OP_DEGREE) begin
                                n_res.result_value = RV_W'(r_deg);
                            end else if (r_hold_v) begin
                                n_res.neighbor_node = r_hold_node;
                                n_res.result_value  = RV_W'(r_hold_w);
                            end else begin
                                n_res.status = STS_NO_NBR;
                            end
                        end
                    end
                end
            end

            S_PUSH: begin
                o_push = i_out_ready;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_edges  <= '0;
            r_rd_v   <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_edges  <= n_edges;
            r_rd_v   <= n_rd_v;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_u         <= n_u;
        r_v         <= n_v;
        r_w         <= n_w;
        r_idx       <= n_idx;
        r_deg       <= n_deg;
        r_k         <= n_k;
        r_hold_node <= n_hold_node;
        r_hold_w    <= n_hold_w;
        r_res       <= n_res;
    end

    assign o_stat = '{
        clearing: (r_state == S_CLEAR),
        idle:     (r_state == S_IDLE),
        edges:    r_edges
    };

endmodule

`default_nettype wire

// ----- rtl/adjacency_matrix_graph_store_unit.sv -----
// Weighted undirected graph store, adjacency matrix in one on-chip RAM.
// Channels: i_req takes requests (op, node_u, node_v, edge_weight); o_rsp
// delivers results (status, neighbor_node, result_value, edge_count, last);
// i_cfg writes node_count and is always ready.
// One request is worked on at a time. An add edge checks labels, self loop
// and weight, reads the entry to refuse an existing edge, then writes the
// entry and its mirror. A weight query reads the entry; an illegal label goes
// straight to the result. The row walk of a degree or listing request reads
// one matrix entry per cycle through the single RAM read port while no held
// result stalls it. A listing gives one result per neighbor, up to
// MAX_RESULTS, or one STS_NO_NBR result if there is none; the last is marked.
// After reset the RAM is swept to zero, one entry per cycle, over all
// MAX_NODES * MAX_NODES entries (1024 at the default); i_req.ready stays low
// meanwhile. Edge count and node_count (32) are reset at once.
// A stalled receiver holds the output register; a listing then pauses its
// row walk until the held result is taken. The next request is accepted
// while the final result of the previous one still waits in the register.
`default_nettype none
`include "adjacency_matrix_graph_store_unit_macros.svh"

module adjacency_matrix_graph_store_unit import amg_pkg::*; #(
    parameter int unsigned MAX_NODES   = MAX_NODES_DEF,
    parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    amg_cfg_if.sink   i_cfg,
    amg_req_if.sink   i_req,
    amg_rsp_if.source o_rsp
);

    localparam int unsigned DEPTH  = MAX_NODES * MAX_NODES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);

    // configuration register
    logic [NCFG_W-1:0] r_node_count;
    logic [NCFG_W-1:0] n_node_count;
    // node count clipped to the matrix size
    logic [CNT_W-1:0]  active_n;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [WEIGHT_BITS-1:0] mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [WEIGHT_BITS-1:0] mem_rdata;

    logic  push;
    t_rsp  push_rsp;
    logic  out_ready;
    t_stat stat;

    assign i_cfg.ready  = 1'b1;
    assign n_node_count = i_cfg.valid ? i_cfg.node_count : r_node_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else begin
            r_node_count <= n_node_count;
        end
    end

    assign active_n = (CMP_W'(r_node_count) > CMP_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                                  : CNT_W'(r_node_count);

    amg_ctrl #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_active_n  (active_n),
        .i_req       (i_req),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_push      (push),
        .o_push_rsp  (push_rsp),
        .i_out_ready (out_ready),
        .o_stat      (stat)
    );

    amg_wmem #(
        .DEPTH (DEPTH),
        .WIDTH (WEIGHT_BITS)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    amg_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rsp   (push_rsp),
        .o_ready (out_ready),
        .o_rsp   (o_rsp)
    );

    // no request may slip in while the RAM sweep is still running
    `AMG_ASSERT_NOW(a_no_req_in_clear, stat.clearing, !i_req.ready, "request ready during clear")

    // strictly one request worked on at a time
    `AMG_ASSERT_NEXT(a_one_req, i_req.valid && i_req.ready, !i_req.ready, "back to back accept")

    // edge counter only holds or steps up by one
    `AMG_ASSERT_NOW(a_edge_step, $past(i_rst_n),
        (stat.edges >= $past(stat.edges)) && ((stat.edges - $past(stat.edges)) <= 1),
        "edge count jump")

endmodule

`default_nettype wire

// ----- bench/adjacency_matrix_graph_store_unit_checker.sv -----
`default_nettype none

// Watches the config, request and result channels of the graph store.
// Keeps a shadow copy of the matrix, computes the results of every accepted
// request and compares them in order against what the block delivers.
module adjacency_matrix_graph_store_unit_checker import amg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    amg_cfg_if        i_cfg,
    amg_req_if        i_req,
    amg_rsp_if        i_rsp,
    output int        o_fail_count,
    output int        o_pending
);

    logic [WIN_W-1:0]  shadow_weights [MAX_NODES_DEF][MAX_NODES_DEF];
    logic [EC_W-1:0]   shadow_edges;
    logic [NCFG_W-1:0] shadow_node_count;
    t_rsp              pending_results [$];

    // counts above MAX_NODES behave as MAX_NODES
    function automatic int unsigned labels_in_use();
        if (shadow_node_count > MAX_NODES_DEF) begin
            return MAX_NODES_DEF;
        end
        return shadow_node_count;
    endfunction

    function automatic void queue_result(t_status st, logic [LBL_W-1:0] nbr,
                                         logic [RV_W-1:0] value, logic fin);
        t_rsp r;
        r.status        = st;
        r.neighbor_node = nbr;
        r.result_value  = value;
        r.edge_count    = shadow_edges;
        r.last          = fin;
        pending_results = {pending_results, r};
    endfunction

    function automatic void apply_request(t_op op, logic [LBL_W-1:0] u,
                                          logic [LBL_W-1:0] v, logic [WIN_W-1:0] w);
        int unsigned n;
        int unsigned hits;
        int unsigned k;
        int unsigned i;
        logic        u_ok;
        logic        v_ok;
        n    = labels_in_use();
        u_ok = (u < n);
        v_ok = (v < n);
        hits = 0;
        k    = 0;
        case (op)
            OP_ADD: begin
                if (!u_ok || !v_ok || u == v || w == '0 || shadow_weights[u][v] != '0) begin
                    queue_result(STS_BAD_EDGE, '0, '0, 1'b1);
                end else begin
                    shadow_weights[u][v] = w;
                    shadow_weights[v][u] = w;
                    if (shadow_edges != EDGE_CNT_MAX) begin
                        shadow_edges = shadow_edges + 1'b1;
                    end
                    queue_result(STS_OK, '0, '0, 1'b1);
                end
            end
            OP_QUERY: begin
                if (!u_ok || !v_ok) begin
                    queue_result(STS_ILLEGAL, '0, '0, 1'b1);
                end else begin
                    queue_result(STS_OK, '0, shadow_weights[u][v], 1'b1);
                end
            end
            OP_DEGREE: begin
                if (!u_ok) begin
                    queue_result(STS_ILLEGAL, '0, '0, 1'b1);
                end else begin
                    for (i = 0; i < n; i++) begin
                        if (shadow_weights[u][i] != '0) begin
                            hits++;
                        end
                    end
                    queue_result(STS_OK, '0, RV_W'(hits), 1'b1);
                end
            end
            default: begin
                if (!u_ok) begin
                    queue_result(STS_ILLEGAL, '0, '0, 1'b1);
                end else begin
                    // listing is capped at MAX_RESULTS entries
                    for (i = 0; i < n; i++) begin
                        if (shadow_weights[u][i] != '0 && hits < MAX_RESULTS) begin
                            hits++;
                        end
                    end
                    if (hits == 0) begin
                        queue_result(STS_NO_NBR, '0, '0, 1'b1);
                    end else begin
                        for (i = 0; i < n && k < hits; i++) begin
                            if (shadow_weights[u][i] != '0) begin
                                queue_result(STS_OK, LBL_W'(i), shadow_weights[u][i],
                                             k == hits - 1);
                                k++;
                            end
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic int field_differs(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            foreach (shadow_weights[a, b]) begin
                shadow_weights[a][b] = '0;
            end
            shadow_edges      = '0;
            shadow_node_count = NODE_COUNT_RST;
            pending_results.delete();
            o_fail_count      = 0;
            o_pending        <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                shadow_node_count = i_cfg.node_count;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, i_rsp.status);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    o_fail_count += field_differs("status", want.status, i_rsp.status);
                    o_fail_count += field_differs("neighbor_node", want.neighbor_node,
                                                  i_rsp.neighbor_node);
                    o_fail_count += field_differs("result_value", want.result_value,
                                                  i_rsp.result_value);
                    o_fail_count += field_differs("edge_count", want.edge_count,
                                                  i_rsp.edge_count);
                    o_fail_count += field_differs("last", want.last, i_rsp.last);
                end
            end
            if (i_req.valid && i_req.ready) begin
                apply_request(t_op'(i_req.op), i_req.node_u, i_req.node_v,
                              i_req.edge_weight);
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

`default_nettype wire

// ----- bench/adjacency_matrix_graph_store_unit_tb.sv -----
`default_nettype none

// Top of the graph store bench: clock, reset, request and config stimulus,
// result-side backpressure and the final verdict. Prediction and comparison
// live in the checker instantiated beside the block.
module adjacency_matrix_graph_store_unit_tb;
    import amg_pkg::*;

    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int HOLD_OFF_CYCLES = 300;
    // the limit sits well above the slowest legal run (RAM sweep, full-row
    // walks, every result stalled), which leaves ample margin
    localparam int CYCLE_LIMIT     = 1_000_000;

    logic clk;
    logic rst_n;

    amg_cfg_if cfg_bus ();
    amg_req_if req_bus ();
    amg_rsp_if rsp_bus ();

    int fail_count;
    int outstanding;
    int cycle_count;

    // current node_count as the block sees it, used to aim labels
    logic [NCFG_W-1:0] cur_nodes;

    // idling and backpressure controls, read by the stimulus and result side
    bit req_idle_on;
    bit rsp_idle_on;
    int hold_off_asked;
    int hold_off_served;

    // node_count settings of the random phases, extremes included:
    // zero (every label illegal), one, two, and 63 (acts as full size)
    logic [NCFG_W-1:0] phase_nodes [PHASES] = '{
        6'd32, 6'd8, 6'd2, 6'd32, 6'd17, 6'd0, 6'd1, 6'd63, 6'd5, 6'd32
    };

    adjacency_matrix_graph_store_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    adjacency_matrix_graph_store_unit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_bus),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Present one request and hold it until the block takes it. A random gap
    // may come first; valid is only lowered there, so back-to-back requests
    // keep valid high with no glitch in between.
    task automatic send_request(t_op op, logic [LBL_W-1:0] u, logic [LBL_W-1:0] v,
                                logic [WIN_W-1:0] w);
        if (req_idle_on && $urandom_range(0, 4) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.op          <= op;
        req_bus.node_u      <= u;
        req_bus.node_v      <= v;
        req_bus.edge_weight <= w;
        @(posedge clk);
        while (req_bus.ready !== 1'b1) @(posedge clk);
    endtask

    // Stop offering requests and wait until every predicted result is in.
    // Every request yields at least one result, so an empty queue means idle.
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // node_count is only changed with the block idle
    task automatic set_node_count(logic [NCFG_W-1:0] n);
        wait_drained();
        cfg_bus.valid      <= 1'b1;
        cfg_bus.node_count <= n;
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1) @(posedge clk);
        cfg_bus.valid <= 1'b0;
        cur_nodes = n;
    endtask

    // Mostly legal labels for the current node count, with some from the
    // full 5-bit range to hit the illegal-label paths.
    function automatic logic [LBL_W-1:0] pick_label();
        int unsigned active;
        active = (cur_nodes > MAX_NODES_DEF) ? MAX_NODES_DEF : cur_nodes;
        if (active == 0 || $urandom_range(0, 9) == 0) begin
            return LBL_W'($urandom_range(0, 31));
        end
        return LBL_W'($urandom_range(0, active - 1));
    endfunction

    task automatic send_random_item();
        int unsigned pick;
        t_op         op;
        logic [LBL_W-1:0] u;
        logic [LBL_W-1:0] v;
        logic [WIN_W-1:0] w;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            op = OP_ADD;
        end else if (pick < 60) begin
            op = OP_QUERY;
        end else if (pick < 80) begin
            op = OP_LIST;
        end else begin
            op = OP_DEGREE;
        end
        u = pick_label();
        v = pick_label();
        // node 0 acts as a hub so its row grows toward a full listing
        if (op == OP_ADD && $urandom_range(0, 3) == 0) begin
            u = '0;
        end
        // keep self loops as occasional noise only
        if (op == OP_ADD && u == v && $urandom_range(0, 3) != 0) begin
            v = pick_label();
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            w = '0;
        end else if (pick == 1) begin
            w = '1;
        end else begin
            w = WIN_W'($urandom_range(1, 65535));
        end
        send_request(op, u, v, w);
    endtask

    // Result side: random stall bursts, plus one long hold-off on request
    // from the stimulus so the block fills up and pushes back on i_req.
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_served != hold_off_asked) begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_served++;
                rsp_bus.ready <= 1'b1;
            end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                rsp_bus.ready <= 1'b1;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        int p;
        int j;
        rst_n               <= 1'b0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.node_count  <= NODE_COUNT_RST;
        req_bus.valid       <= 1'b0;
        req_bus.op          <= OP_ADD;
        req_bus.node_u      <= '0;
        req_bus.node_v      <= '0;
        req_bus.edge_weight <= '0;
        cur_nodes            = NODE_COUNT_RST;
        req_idle_on          = 1'b1;
        rsp_idle_on          = 1'b1;
        hold_off_asked       = 0;
        hold_off_served      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset node count of 32.
        // The first request waits out the RAM sweep through ready.
        send_request(OP_LIST,   5'd0,  5'd0,  16'd0);       // empty row
        send_request(OP_DEGREE, 5'd0,  5'd0,  16'd0);
        send_request(OP_ADD,    5'd0,  5'd31, 16'hFFFF);    // extreme labels/weight
        send_request(OP_ADD,    5'd0,  5'd31, 16'd5);       // edge exists
        send_request(OP_ADD,    5'd31, 5'd0,  16'd7);       // exists, mirrored
        send_request(OP_ADD,    5'd3,  5'd3,  16'd9);       // self loop
        send_request(OP_ADD,    5'd1,  5'd2,  16'd0);       // zero weight
        send_request(OP_ADD,    5'd0,  5'd1,  16'd1);
        send_request(OP_ADD,    5'd0,  5'd2,  16'h8000);
        send_request(OP_QUERY,  5'd31, 5'd0,  16'd0);
        send_request(OP_QUERY,  5'd5,  5'd6,  16'd0);       // no edge reads zero
        send_request(OP_LIST,   5'd0,  5'd0,  16'd0);       // three neighbors
        send_request(OP_DEGREE, 5'd31, 5'd0,  16'd0);

        // shrink while edges exist: node 31 drops out of view
        set_node_count(6'd4);
        send_request(OP_ADD,    5'd0,  5'd5,  16'd3);       // label out of range
        send_request(OP_QUERY,  5'd0,  5'd31, 16'd0);
        send_request(OP_LIST,   5'd7,  5'd0,  16'd0);
        send_request(OP_DEGREE, 5'd31, 5'd0,  16'd0);
        send_request(OP_LIST,   5'd0,  5'd0,  16'd0);

        // zero nodes: nothing is legal
        set_node_count(6'd0);
        send_request(OP_QUERY,  5'd0,  5'd0,  16'd0);
        send_request(OP_ADD,    5'd0,  5'd1,  16'd3);
        send_request(OP_DEGREE, 5'd0,  5'd0,  16'd0);

        // above the matrix size: behaves as full size
        set_node_count(6'd63);
        send_request(OP_LIST,   5'd0,  5'd0,  16'd0);

        // single node: its row holds no edge in view
        set_node_count(6'd1);
        send_request(OP_LIST,   5'd0,  5'd0,  16'd0);
        send_request(OP_DEGREE, 5'd0,  5'd0,  16'd0);

        // Random phases, each under its own node_count. Phase 4 runs with
        // no idling; the last two are the idle-free tail of the run.
        for (p = 0; p < PHASES; p++) begin
            set_node_count(phase_nodes[p]);
            req_idle_on = (p != 4) && (p < PHASES - 2);
            rsp_idle_on = (p != 4) && (p < PHASES - 2);
            for (j = 0; j < ITEMS_PER_PHASE; j++) begin
                if (p == 3 && j == 10) begin
                    hold_off_asked++;
                end
                // sender pause mid-phase until the pipe is empty
                if (p == 1 && j == 24) begin
                    wait_drained();
                end
                send_random_item();
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
